// ----- src/bgrs_pkg.sv -----
// Shared types and constants of the broadcast gradient reduce-sum block.
package bgrs_pkg;

   // Field widths of the transaction payloads.
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 12;
   localparam int SIZE_W  = 16;
   localparam int RANK_W  = 3;
   localparam int KEEP_W  = 4;
   localparam int TDATA_W = 48;
   localparam int TUSER_W = 2;

   // Number of dimension slots that the register file carries.
   localparam int SLOT_COUNT = 4;

   // Register port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [2:0] REG_RANK  = 3'd0;
   localparam logic [2:0] REG_DIM_0 = 3'd1;
   localparam logic [2:0] REG_DIM_1 = 3'd2;
   localparam logic [2:0] REG_DIM_2 = 3'd3;
   localparam logic [2:0] REG_DIM_3 = 3'd4;
   localparam logic [2:0] REG_KEEP  = 3'd5;

   // Operation carried in req_tuser[0].
   typedef enum logic {
      REQ_ACCUM = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [RANK_W-1:0]                  rank;
      logic [SLOT_COUNT-1:0][SIZE_W-1:0] dim_size;
      logic [KEEP_W-1:0]                  keep_mask;
   } cfg_type;

endpackage

// ----- src/bgrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bgrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bgrs_front.sv -----
// Front end: accepts requests, tracks the tensor position and forms the target offset.
module bgrs_front #(
   parameter int MAX_RANK  = 4,
   parameter int OUT_DEPTH = 4096,
   localparam int AW = $clog2(OUT_DEPTH),
   localparam int EW = 2 + AW + bgrs_pkg::DATA_W + bgrs_pkg::IDX_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bgrs_pkg::cfg_type             cfg,
   input  logic                          enable,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_is_read,
   input  logic                          req_start,
   input  logic [bgrs_pkg::DATA_W-1:0]   req_value,
   input  logic [bgrs_pkg::IDX_W-1:0]    req_index,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [EW-1:0]                 push_data
);

   localparam int SLOTS = (MAX_RANK < bgrs_pkg::SLOT_COUNT) ? MAX_RANK : bgrs_pkg::SLOT_COUNT;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ACC_W = AW + 1;
   localparam int HW    = ACC_W + bgrs_pkg::SIZE_W + 1;
   localparam int SZ    = bgrs_pkg::SIZE_W;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CALC = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type st_ff, st_in;

   logic [SLOTS-1:0][SZ-1:0] pos_ff, pos_in;
   logic [SLOTS-1:0][SZ-1:0] pos_base, pos_next;
   logic [SLOTS-1:0][SZ-1:0] sh_pos_ff, sh_pos_in;
   logic [SLOTS-1:0][SZ-1:0] sh_size_ff, sh_size_in;
   logic [SLOTS-1:0]         sh_keep_ff, sh_keep_in;
   logic [SLOTS-1:0][SZ-1:0] size_eff;
   logic [SLOTS-1:0]         slot_active;

   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [SW-1:0]                step_ff, step_in;
   logic [bgrs_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [bgrs_pkg::IDX_W-1:0]   ridx_ff, ridx_in;
   logic                         is_read_ff, is_read_in;
   logic                         rd_range_ff, rd_range_in;

   logic [bgrs_pkg::RANK_W-1:0]  act_rank;
   logic [ACC_W+SZ-1:0]          prod;
   logic [HW-1:0]                hsum;
   logic [ACC_W-1:0]             hacc;
   logic                         req_fire;
   logic                         in_range;

   assign req_tready = (st_ff == F_IDLE) && enable;
   assign req_fire   = req_tvalid && req_tready;

   // Effective rank and dimension sizes; zero values act as one.
   always_comb begin
      act_rank = (cfg.rank == '0) ? bgrs_pkg::RANK_W'(1) : cfg.rank;
      if (act_rank > bgrs_pkg::RANK_W'(SLOTS)) begin
         act_rank = bgrs_pkg::RANK_W'(SLOTS);
      end
      for (int d = 0; d < SLOTS; d++) begin
         size_eff[d]    = (cfg.dim_size[d] == '0) ? SZ'(1) : cfg.dim_size[d];
         slot_active[d] = bgrs_pkg::RANK_W'(d) < act_rank;
         pos_base[d]    = req_start ? '0 : pos_ff[d];
      end
   end

   // Row-major advance of the position counter, innermost slot first.
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int d = SLOTS - 1; d >= 0; d--) begin
         pos_next[d] = pos_base[d];
         if (slot_active[d] && carry) begin
            if (pos_base[d] >= size_eff[d] - SZ'(1)) begin
               pos_next[d] = '0;
            end else begin
               pos_next[d] = pos_base[d] + SZ'(1);
               carry       = 1'b0;
            end
         end
      end
   end

   // One Horner step of the offset; saturates at the store depth, which marks a drop.
   always_comb begin
      prod = acc_ff * sh_size_ff[0];
      hsum = HW'(prod) + HW'(sh_pos_ff[0]);
      hacc = (hsum >= HW'(OUT_DEPTH)) ? ACC_W'(OUT_DEPTH) : hsum[ACC_W-1:0];
   end

   // Sequencer: capture, iterate over the slots, hand the entry to the queue.
   always_comb begin
      st_in       = st_ff;
      pos_in      = pos_ff;
      sh_pos_in   = sh_pos_ff;
      sh_size_in  = sh_size_ff;
      sh_keep_in  = sh_keep_ff;
      acc_in      = acc_ff;
      step_in     = step_ff;
      value_in    = value_ff;
      ridx_in     = ridx_ff;
      is_read_in  = is_read_ff;
      rd_range_in = rd_range_ff;
      case (st_ff)
         F_IDLE: begin
            if (req_fire) begin
               value_in    = req_value;
               ridx_in     = req_index;
               is_read_in  = req_is_read;
               rd_range_in = 32'(req_index) < 32'(OUT_DEPTH);
               step_in     = '0;
               if (req_is_read) begin
                  acc_in = ACC_W'(req_index);
                  st_in  = F_PUSH;
               end else begin
                  pos_in     = pos_next;
                  sh_pos_in  = pos_base;
                  sh_size_in = size_eff;
                  for (int d = 0; d < SLOTS; d++) begin
                     sh_keep_in[d] = slot_active[d] & cfg.keep_mask[d];
                  end
                  acc_in = '0;
                  st_in  = F_CALC;
               end
            end
         end
         F_CALC: begin
            if (sh_keep_ff[0]) begin
               acc_in = hacc;
            end
            for (int d = 0; d < SLOTS - 1; d++) begin
               sh_pos_in[d]  = sh_pos_ff[d+1];
               sh_size_in[d] = sh_size_ff[d+1];
               sh_keep_in[d] = sh_keep_ff[d+1];
            end
            sh_keep_in[SLOTS-1] = 1'b0;
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(SLOTS - 1)) begin
               st_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               st_in = F_IDLE;
            end
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
   end

   // Control state and position counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= F_IDLE;
         pos_ff     <= '0;
         sh_keep_ff <= '0;
         step_ff    <= '0;
      end else begin
         st_ff      <= st_in;
         pos_ff     <= pos_in;
         sh_keep_ff <= sh_keep_in;
         step_ff    <= step_in;
      end
   end

   // Working payload.
   always_ff @(posedge clock) begin
      sh_pos_ff   <= sh_pos_in;
      sh_size_ff  <= sh_size_in;
      acc_ff      <= acc_in;
      value_ff    <= value_in;
      ridx_ff     <= ridx_in;
      is_read_ff  <= is_read_in;
      rd_range_ff <= rd_range_in;
   end

   // Queue entry: kind, in-range flag, address, value, echoed index.
   assign in_range   = is_read_ff ? rd_range_ff : (acc_ff < ACC_W'(OUT_DEPTH));
   assign push_valid = (st_ff == F_PUSH);
   assign push_data  = {is_read_ff, in_range, acc_ff[AW-1:0], value_ff, ridx_ff};

   a_calc_done: assert property (@(posedge clock) disable iff (reset)
      (st_ff == F_CALC && step_ff == SW'(SLOTS - 1)) |=> (st_ff == F_PUSH))
      else $error("offset iteration did not finish after the last slot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (st_ff != F_IDLE))
      else $error("front end stayed idle after taking a transaction");

endmodule

// ----- src/bgrs_queue.sv -----
// Two-entry queue between the front end and the back end.
module bgrs_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [1:0][WIDTH-1:0] entry_ff, entry_in;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push_fire;
   logic                  pop_fire;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (pop_fire) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 2'd1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- src/bgrs_back.sv -----
// Back end: clears the accumulator store after reset and runs read-modify-write per entry.
module bgrs_back #(
   parameter int OUT_DEPTH = 4096,
   localparam int AW = $clog2(OUT_DEPTH),
   localparam int EW = 2 + AW + bgrs_pkg::DATA_W + bgrs_pkg::IDX_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  logic [EW-1:0]                pop_data,
   output logic                         clear_done,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bgrs_pkg::DATA_W-1:0]  rsp_sum,
   output logic [bgrs_pkg::IDX_W-1:0]   rsp_index
);

   localparam int DW = bgrs_pkg::DATA_W;
   localparam int IW = bgrs_pkg::IDX_W;

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_MOD   = 3'b100
   } back_state_type;

   back_state_type st_ff, st_in;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic          cur_is_read_ff, cur_is_read_in;
   logic          cur_in_range_ff, cur_in_range_in;
   logic [AW-1:0] cur_addr_ff, cur_addr_in;
   logic [DW-1:0] cur_value_ff, cur_value_in;
   logic [IW-1:0] cur_index_ff, cur_index_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_sum_ff, rsp_sum_in;
   logic [IW-1:0] rsp_index_ff, rsp_index_in;

   logic          pop_is_read;
   logic          pop_in_range;
   logic [AW-1:0] pop_addr;
   logic [DW-1:0] pop_value;
   logic [IW-1:0] pop_index;
   logic          pop_fire;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [DW-1:0] rd_data;

   // Add two Q16.16 values and clamp to the 32-bit range.
   function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
      logic [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      case (s[DW:DW-1])
         2'b01:   sat_add = {1'b0, {(DW-1){1'b1}}};
         2'b10:   sat_add = {1'b1, {(DW-1){1'b0}}};
         default: sat_add = s[DW-1:0];
      endcase
   endfunction

   // Unpack the queue entry.
   assign pop_index    = pop_data[IW-1:0];
   assign pop_value    = pop_data[IW+DW-1:IW];
   assign pop_addr     = pop_data[IW+DW+AW-1:IW+DW];
   assign pop_in_range = pop_data[IW+DW+AW];
   assign pop_is_read  = pop_data[IW+DW+AW+1];

   // A read waits for the result register to be free.
   assign pop_ready  = (st_ff == B_IDLE) && !(pop_is_read && rsp_valid_ff);
   assign pop_fire   = pop_valid && pop_ready;
   assign clear_done = (st_ff != B_CLEAR);

   bgrs_ram #(
      .WIDTH (DW),
      .DEPTH (OUT_DEPTH)
   ) u_accum_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (pop_fire),
      .rd_addr (pop_addr),
      .rd_data (rd_data)
   );

   // Clearing pass, then read on acceptance in B_IDLE and write back in B_MOD, in the next cycle.
   always_comb begin
      st_in           = st_ff;
      clr_addr_in     = clr_addr_ff;
      cur_is_read_in  = cur_is_read_ff;
      cur_in_range_in = cur_in_range_ff;
      cur_addr_in     = cur_addr_ff;
      cur_value_in    = cur_value_ff;
      cur_index_in    = cur_index_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_sum_in      = rsp_sum_ff;
      rsp_index_in    = rsp_index_ff;
      wr_en           = 1'b0;
      wr_addr         = cur_addr_ff;
      wr_data         = '0;
      case (st_ff)
         B_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(OUT_DEPTH - 1)) begin
               st_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_fire) begin
               cur_is_read_in  = pop_is_read;
               cur_in_range_in = pop_in_range;
               cur_addr_in     = pop_addr;
               cur_value_in    = pop_value;
               cur_index_in    = pop_index;
               st_in           = B_MOD;
            end
         end
         B_MOD: begin
            wr_en   = cur_in_range_ff;
            wr_data = cur_is_read_ff ? '0 : sat_add(rd_data, cur_value_ff);
            if (cur_is_read_ff) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = cur_in_range_ff ? rd_data : '0;
               rsp_index_in = cur_index_ff;
            end
            st_in = B_IDLE;
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_is_read_ff  <= cur_is_read_in;
      cur_in_range_ff <= cur_in_range_in;
      cur_addr_ff     <= cur_addr_in;
      cur_value_ff    <= cur_value_in;
      cur_index_ff    <= cur_index_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_index_ff    <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_index  = rsp_index_ff;

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == B_MOD && cur_is_read_ff))
      else $error("result raised without a read transaction in write-back");

   a_mod_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_MOD) |=> (st_ff == B_IDLE))
      else $error("write-back took more than one cycle");

   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_CLEAR && clr_addr_ff == AW'(OUT_DEPTH - 1)) |=> (st_ff == B_IDLE))
      else $error("clearing pass did not end at the last entry");

endmodule

// ----- src/broadcast_gradient_reduce_sum_top.sv -----
// Top level of the broadcast gradient reduce-sum block: register file and datapath.
//
// Usage: gradient elements and read requests enter on the req_ stream; req_tuser[0]
// selects accumulate (0) or read-and-clear (1), req_tuser[1] marks the first element
// of a tensor. Each accumulate adds its Q16.16 value, saturated, into the entry that
// the kept dimensions of its row-major position select; it produces no result. Each
// read returns the entry and its index on the rsp_ stream and clears the entry. The user
// must write csr_ port shape registers only while the block is idle; nothing enforces it.
// Throughput: an accumulate occupies the front end while the offset unit does one
// multiply-add per dimension slot per cycle; the front end takes no new request until
// the last entry is in the queue. The back end does a read-modify-write per transaction
// on the accumulator memory, with one write and one read port, before taking the next.
// A read passes the front end, the queue and the back end before its result is registered.
// Reset: registers return to rank 1, sizes 1, all dimensions kept, and the back end
// clears the accumulator memory entry by entry, during which req_tready is low.
// Stall: a pending result holds in its output register. Accumulates ahead of the next
// read keep flowing; that read waits at the head of the two-entry queue until the result
// register is free, everything behind it waits too, and req_tready then drops.
module broadcast_gradient_reduce_sum_top #(
   parameter int MAX_RANK  = 4,
   parameter int OUT_DEPTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bgrs_pkg::TDATA_W-1:0]       req_tdata,   // grad_value[31:0], read_index[43:32]
   input  logic [bgrs_pkg::TUSER_W-1:0]       req_tuser,   // req_type[0], start_of_tensor[1]
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bgrs_pkg::TDATA_W-1:0]       rsp_tdata,   // sum_value[31:0], entry_index[43:32]
   // Register port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bgrs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bgrs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bgrs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int AW    = $clog2(OUT_DEPTH);
   localparam int EW    = 2 + AW + bgrs_pkg::DATA_W + bgrs_pkg::IDX_W;
   localparam int PAD_W = bgrs_pkg::TDATA_W - bgrs_pkg::DATA_W - bgrs_pkg::IDX_W;
   localparam int DW    = bgrs_pkg::DATA_W;
   localparam int IW    = bgrs_pkg::IDX_W;

   bgrs_pkg::cfg_type cfg_ff, cfg_in;

   logic [2:0]    reg_sel;
   logic          csr_wr;
   logic          clear_done;
   logic          push_valid;
   logic          push_ready;
   logic [EW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [EW-1:0] pop_data;
   logic [DW-1:0] rsp_sum;
   logic [IW-1:0] rsp_index;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_sel)
            bgrs_pkg::REG_RANK:  cfg_in.rank        = csr_pwdata[bgrs_pkg::RANK_W-1:0];
            bgrs_pkg::REG_DIM_0: cfg_in.dim_size[0] = csr_pwdata[bgrs_pkg::SIZE_W-1:0];
            bgrs_pkg::REG_DIM_1: cfg_in.dim_size[1] = csr_pwdata[bgrs_pkg::SIZE_W-1:0];
            bgrs_pkg::REG_DIM_2: cfg_in.dim_size[2] = csr_pwdata[bgrs_pkg::SIZE_W-1:0];
            bgrs_pkg::REG_DIM_3: cfg_in.dim_size[3] = csr_pwdata[bgrs_pkg::SIZE_W-1:0];
            bgrs_pkg::REG_KEEP:  cfg_in.keep_mask   = csr_pwdata[bgrs_pkg::KEEP_W-1:0];
            default:             cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rank      <= bgrs_pkg::RANK_W'(1);
         cfg_ff.dim_size  <= {bgrs_pkg::SLOT_COUNT{bgrs_pkg::SIZE_W'(1)}};
         cfg_ff.keep_mask <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      case (reg_sel)
         bgrs_pkg::REG_RANK:  csr_prdata = bgrs_pkg::CSR_DATA_W'(cfg_ff.rank);
         bgrs_pkg::REG_DIM_0: csr_prdata = bgrs_pkg::CSR_DATA_W'(cfg_ff.dim_size[0]);
         bgrs_pkg::REG_DIM_1: csr_prdata = bgrs_pkg::CSR_DATA_W'(cfg_ff.dim_size[1]);
         bgrs_pkg::REG_DIM_2: csr_prdata = bgrs_pkg::CSR_DATA_W'(cfg_ff.dim_size[2]);
         bgrs_pkg::REG_DIM_3: csr_prdata = bgrs_pkg::CSR_DATA_W'(cfg_ff.dim_size[3]);
         bgrs_pkg::REG_KEEP:  csr_prdata = bgrs_pkg::CSR_DATA_W'(cfg_ff.keep_mask);
         default:             csr_prdata = '0;
      endcase
   end

   bgrs_front #(
      .MAX_RANK  (MAX_RANK),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .enable      (clear_done),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_is_read (req_tuser[0]),
      .req_start   (req_tuser[1]),
      .req_value   (req_tdata[DW-1:0]),
      .req_index   (req_tdata[DW+IW-1:DW]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   bgrs_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bgrs_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .clear_done (clear_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_sum    (rsp_sum),
      .rsp_index  (rsp_index)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_index, rsp_sum};

endmodule
